### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the rate meter checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SWRM_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rate meter check failed");

// Next-cycle implication, disabled in reset.
`define SWRM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rate meter check failed");

`endif

### rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// swrm_pkg
// Types and constants shared by the sliding window rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package swrm_pkg;

  localparam int RING_DEPTH_DEF = 128;
  localparam logic [15:0] WINDOW_RESET = 16'd5000;
  localparam int MS_PER_SECOND = 1000;
  localparam int BYTE_SHIFT = 3;
  localparam logic [7:0] FPS_MAX = 8'd255;

  localparam int STAMP_W = 32;
  localparam int LEN_W = 24;
  localparam int BITS_W = LEN_W + BYTE_SHIFT;
  localparam int WIN_W = 16;
  localparam int TOTAL_W = 34;
  localparam int SPAN_W = STAMP_W + 1;
  localparam int DIVIDEND_W = TOTAL_W;
  localparam int DIVISOR_W = SPAN_W;
  localparam int DIV_CNT_W = $clog2(DIVIDEND_W);
  localparam int FPS_W = 8;
  localparam int FIW_W = 8;

  typedef struct packed {
    logic capture;
    logic drop;
    logic write;
    logic latch_span;
    logic div_start;
    logic div_sel_fps;
    logic cap_bits;
    logic cap_fps;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic expired;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/swrm_ring.sv
// ----------------------------------------------------------------------------
// swrm_ring
// Record store: timestamp and bit length per slot, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_ring
  import swrm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int IDX_W = $clog2(RING_DEPTH)
) (
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [IDX_W-1:0]   waddr_i,
  input  wire logic [STAMP_W-1:0] wstamp_i,
  input  wire logic [BITS_W-1:0]  wbits_i,
  input  wire logic [IDX_W-1:0]   raddr_i,
  output logic      [STAMP_W-1:0] rstamp_o,
  output logic      [BITS_W-1:0]  rbits_o
);

  logic [STAMP_W-1:0] stamp_mem [RING_DEPTH];
  logic [BITS_W-1:0]  bits_mem  [RING_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      stamp_mem[waddr_i] <= wstamp_i;
      bits_mem[waddr_i]  <= wbits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rstamp_o <= stamp_mem[raddr_i];
    rbits_o  <= bits_mem[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// swrm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_div
  import swrm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic      [DIVIDEND_W-1:0] quotient_o
);

  logic                  busy_q;
  logic                  done_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVIDEND_W-1:0] rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;
  logic [DIVIDEND_W-1:0] rem_sh;
  logic [DIVIDEND_W-1:0] diff;
  logic                  ge;

  assign rem_sh = {rem_q[DIVIDEND_W-2:0], quo_q[DIVIDEND_W-1]};
  assign ge     = rem_sh >= DIVIDEND_W'(dsr_q);
  assign diff   = rem_sh - DIVIDEND_W'(dsr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(DIVIDEND_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff : rem_sh;
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

### rtl/swrm_datapath.sv
// ----------------------------------------------------------------------------
// swrm_datapath
// Ring pointers, running bit total, age test, divisions and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_datapath
  import swrm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WIN_W-1:0]   cfg_wdata_i,
  input  wire logic [STAMP_W-1:0] now_ms_i,
  input  wire logic [LEN_W-1:0]   length_bytes_i,
  input  wire dp_cmd_t            cmd_i,
  output dp_status_t              status_o,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic      [TOTAL_W-1:0] bits_per_ms_o,
  output logic      [FPS_W-1:0]   frames_per_second_o,
  output logic      [FIW_W-1:0]   frames_in_window_o
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  logic [WIN_W-1:0]      window_q;
  logic [STAMP_W-1:0]    now_q;
  logic [BITS_W-1:0]     bits_q;
  logic [IDX_W-1:0]      newest_q;
  logic [IDX_W-1:0]      oldest_q;
  logic [CNT_W-1:0]      count_q;
  logic [TOTAL_W-1:0]    total_q;
  logic [SPAN_W-1:0]     span_q;
  logic [TOTAL_W-1:0]    rate_q;
  logic [FPS_W-1:0]      fps_q;
  logic                  out_valid_q;
  logic [TOTAL_W-1:0]    out_bits_q;
  logic [FPS_W-1:0]      out_fps_q;
  logic [FIW_W-1:0]      out_fiw_q;

  logic [IDX_W-1:0]      newest_inc;
  logic [IDX_W-1:0]      oldest_inc;
  logic [STAMP_W-1:0]    rd_stamp;
  logic [BITS_W-1:0]     rd_bits;
  logic [STAMP_W-1:0]    age;
  logic                  empty;
  logic [DIVIDEND_W-1:0] fps_dividend;
  logic [DIVIDEND_W-1:0] dividend;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;

  assign newest_inc = (newest_q == IDX_W'(RING_DEPTH - 1)) ? '0 : newest_q + IDX_W'(1);
  assign oldest_inc = (oldest_q == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_q + IDX_W'(1);
  assign age        = now_q - rd_stamp;
  assign empty      = count_q == '0;

  assign fps_dividend = DIVIDEND_W'(count_q) * DIVIDEND_W'(MS_PER_SECOND);
  assign dividend     = cmd_i.div_sel_fps ? fps_dividend : total_q;

  swrm_ring #(
    .RING_DEPTH (RING_DEPTH),
    .IDX_W      (IDX_W)
  ) u_ring (
    .clk_i    (clk_i),
    .we_i     (cmd_i.write),
    .waddr_i  (newest_inc),
    .wstamp_i (now_q),
    .wbits_i  (bits_q),
    .raddr_i  (oldest_q),
    .rstamp_o (rd_stamp),
    .rbits_o  (rd_bits)
  );

  swrm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (span_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RESET;
      newest_q    <= '0;
      oldest_q    <= IDX_W'(1);
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (cmd_i.drop) begin
        oldest_q <= oldest_inc;
        count_q  <= count_q - CNT_W'(1);
        total_q  <= total_q - TOTAL_W'(rd_bits);
      end else if (cmd_i.write) begin
        newest_q <= newest_inc;
        count_q  <= count_q + CNT_W'(1);
        total_q  <= total_q + TOTAL_W'(bits_q);
      end
      out_valid_q <= cmd_i.load_out | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q  <= now_ms_i;
      bits_q <= {length_bytes_i, BYTE_SHIFT'(0)};
    end
    if (cmd_i.latch_span) begin
      span_q <= SPAN_W'(age) + SPAN_W'(1);
    end
    if (cmd_i.cap_bits) begin
      rate_q <= quotient;
    end
    if (cmd_i.cap_fps) begin
      fps_q <= (quotient > DIVIDEND_W'(FPS_MAX)) ? FPS_MAX : quotient[FPS_W-1:0];
    end
    if (cmd_i.load_out) begin
      out_bits_q <= empty ? '0 : rate_q;
      out_fps_q  <= empty ? '0 : fps_q;
      out_fiw_q  <= FIW_W'(count_q);
    end
  end

  assign status_o.empty    = empty;
  assign status_o.full     = count_q == CNT_W'(RING_DEPTH);
  assign status_o.expired  = age > STAMP_W'(window_q);
  assign status_o.div_done = div_done;
  assign status_o.out_free = ~out_valid_q | ~out_stall_i;

  assign out_valid_o         = out_valid_q;
  assign bits_per_ms_o       = out_bits_q;
  assign frames_per_second_o = out_fps_q;
  assign frames_in_window_o  = out_fiw_q;

endmodule

`default_nettype wire

### rtl/swrm_ctrl.sv
// ----------------------------------------------------------------------------
// swrm_ctrl
// Sequencer for record, prune, divide and result steps.
// ----------------------------------------------------------------------------
`default_nettype none

module swrm_ctrl
  import swrm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       cmd_i,
  output logic            in_stall_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REC_CHK,
    ST_REC_DROP,
    ST_REC_WR,
    ST_PR_CHK,
    ST_PR_TEST,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_DIV2_GO,
    ST_DIV2_WAIT,
    ST_OUT
  } state_e;

  state_e  state_q, state_d;
  logic    stall_q, stall_d;
  dp_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    stall_d = stall_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.capture = 1'b1;
          stall_d     = 1'b1;
          state_d     = cmd_i ? ST_PR_CHK : ST_REC_CHK;
        end
      end
      ST_REC_CHK: begin
        state_d = status_i.full ? ST_REC_DROP : ST_REC_WR;
      end
      ST_REC_DROP: begin
        cmd.drop = 1'b1;
        state_d  = ST_REC_WR;
      end
      ST_REC_WR: begin
        cmd.write = 1'b1;
        stall_d   = 1'b0;
        state_d   = ST_IDLE;
      end
      ST_PR_CHK: begin
        state_d = status_i.empty ? ST_OUT : ST_PR_TEST;
      end
      ST_PR_TEST: begin
        if (status_i.expired) begin
          cmd.drop = 1'b1;
          state_d  = ST_PR_CHK;
        end else begin
          cmd.latch_span = 1'b1;
          state_d        = ST_DIV1_GO;
        end
      end
      ST_DIV1_GO: begin
        cmd.div_start = 1'b1;
        state_d       = ST_DIV1_WAIT;
      end
      ST_DIV1_WAIT: begin
        if (status_i.div_done) begin
          cmd.cap_bits = 1'b1;
          state_d      = ST_DIV2_GO;
        end
      end
      ST_DIV2_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_fps = 1'b1;
        state_d         = ST_DIV2_WAIT;
      end
      ST_DIV2_WAIT: begin
        if (status_i.div_done) begin
          cmd.cap_fps = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd.load_out = 1'b1;
          stall_d      = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        stall_d = 1'b0;
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= stall_d;
    end
  end

  assign in_stall_o = stall_q;
  assign cmd_o      = cmd;

endmodule

`default_nettype wire

### rtl/sliding_window_rate_meter.sv
// ----------------------------------------------------------------------------
// sliding_window_rate_meter
// Windowed bit rate and frame rate over a ring of recent frame records.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): cmd_i = 0 stores a frame record
// (length_bytes_i * 8 stamped with now_ms_i, oldest dropped when full);
// cmd_i = 1 drops records older than window_ms and returns one result.
// Output channel (out_valid_o / out_stall_i) carries bits_per_ms_o,
// frames_per_second_o and frames_in_window_o; records give no result.
// window_ms is written through cfg_we_i / cfg_wdata_i; the user must write
// it only while idle, which the block does not enforce. One item at a
// time: in_stall_o is high from the transfer until the item is done. A
// record runs a full check, an oldest-record drop when full, and the write;
// a query, an empty check and age test (store read, compare) per record,
// two 34-step divisions unless the ring empties, and the result load.
// The result register is separate from the input side, so the next item
// is taken while a result waits; a query finishing under a stalled
// receiver holds until the register frees. Reset empties the ring (count
// and total cleared, store contents left as is) and sets window to 5000.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_rate_meter
  import swrm_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WIN_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               cmd_i,
  input  wire logic [STAMP_W-1:0] now_ms_i,
  input  wire logic [LEN_W-1:0]   length_bytes_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic      [TOTAL_W-1:0] bits_per_ms_o,
  output logic      [FPS_W-1:0]   frames_per_second_o,
  output logic      [FIW_W-1:0]   frames_in_window_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  swrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  swrm_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .now_ms_i            (now_ms_i),
    .length_bytes_i      (length_bytes_i),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .bits_per_ms_o       (bits_per_ms_o),
    .frames_per_second_o (frames_per_second_o),
    .frames_in_window_o  (frames_in_window_o)
  );

endmodule

`default_nettype wire

### rtl/swrm_checker.sv
// ----------------------------------------------------------------------------
// swrm_checker
// Port-level checks for the rate meter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module swrm_checker
  import swrm_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [TOTAL_W-1:0] bits_per_ms_o,
  input wire logic [FPS_W-1:0]   frames_per_second_o,
  input wire logic [FIW_W-1:0]   frames_in_window_o
);

  logic                             in_xfer;
  logic                             out_held;
  logic [TOTAL_W+FPS_W+FIW_W-1:0]   out_data;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_held = out_valid_o & out_stall_i;
  assign out_data = {bits_per_ms_o, frames_per_second_o, frames_in_window_o};

  `SWRM_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, in_xfer, in_stall_o)
  `SWRM_ASSERT_NOW(a_result_from_query, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))
  `SWRM_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_held, out_valid_o)
  `SWRM_ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_held, $stable(out_data))

endmodule

bind sliding_window_rate_meter swrm_checker u_checker (.*);

`default_nettype wire

### sim/swrm_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate meter testbench package
// Item command codes shared by the stimulus and the scoreboard.
// ----------------------------------------------------------------------------
package swrm_tb_pkg;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_QUERY  = 1'b1
  } meter_cmd_e;

endpackage

### sim/rate_meter_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rate meter scoreboard
// Watches the item and result channels and the window register port, keeps
// its own ring of frame records, and predicts the rate report for each query
// transfer. Reports are compared in order, field by field, as they leave.
// ----------------------------------------------------------------------------
module rate_meter_scoreboard
  import swrm_pkg::*;
  import swrm_tb_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic [STAMP_W-1:0] now_ms_i,
  input  logic [LEN_W-1:0]   length_bytes_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [TOTAL_W-1:0] bits_per_ms_i,
  input  logic [FPS_W-1:0]   frames_per_second_i,
  input  logic [FIW_W-1:0]   frames_in_window_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 peak_fill_o,
  output int                 clamped_o,
  output int                 empty_o
);

  typedef struct packed {
    logic [TOTAL_W-1:0] rate;
    logic [FPS_W-1:0]   fps;
    logic [FIW_W-1:0]   held;
  } rate_report_t;

  logic [STAMP_W-1:0] stamp_mem [RING_DEPTH];
  logic [BITS_W-1:0]  frame_bits_mem [RING_DEPTH];
  int unsigned        head_slot;
  int unsigned        fill;
  logic [TOTAL_W-1:0] window_bits;
  logic [WIN_W-1:0]   window_len;
  rate_report_t       pending_rates [$];

  function automatic int unsigned tail_slot();
    return (head_slot + RING_DEPTH + 1 - fill) % RING_DEPTH;
  endfunction

  function automatic void drop_tail();
    window_bits = window_bits - TOTAL_W'(frame_bits_mem[tail_slot()]);
    fill--;
  endfunction

  function automatic void store_frame(input logic [STAMP_W-1:0] now,
                                      input logic [LEN_W-1:0] len);
    logic [BITS_W-1:0] frame_bits;
    frame_bits = {len, {BYTE_SHIFT{1'b0}}};
    if (fill >= RING_DEPTH) drop_tail();
    head_slot = (head_slot + 1) % RING_DEPTH;
    stamp_mem[head_slot] = now;
    frame_bits_mem[head_slot] = frame_bits;
    fill++;
    window_bits = window_bits + TOTAL_W'(frame_bits);
  endfunction

  // Expire from the oldest end, stopping at the first record still in window.
  function automatic rate_report_t prune_and_rate(input logic [STAMP_W-1:0] now);
    logic [STAMP_W-1:0] age;
    longint unsigned    span;
    longint unsigned    fps;
    longint unsigned    total;
    bit                 young;
    rate_report_t       r;
    r = '0;
    young = 1'b0;
    while (fill > 0 && !young) begin
      age = now - stamp_mem[tail_slot()];
      if (age > STAMP_W'(window_len)) drop_tail();
      else young = 1'b1;
    end
    if (fill != 0) begin
      age = now - stamp_mem[tail_slot()];
      span = age;
      span = span + 1;
      total = window_bits;
      fps = (longint'(fill) * MS_PER_SECOND) / span;
      if (fps > FPS_MAX) fps = FPS_MAX;
      r.rate = TOTAL_W'(total / span);
      r.fps = FPS_W'(fps);
      r.held = FIW_W'(fill);
    end
    return r;
  endfunction

  task automatic flag_field(input string what, input longint unsigned want,
                            input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rate_report_t want;
    if (!rst_ni) begin
      head_slot = 0;
      fill = 0;
      window_bits = '0;
      window_len = WINDOW_RESET;
      pending_rates.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      peak_fill_o = 0;
      clamped_o = 0;
      empty_o = 0;
    end else begin
      if (cfg_we_i) window_len = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (pending_rates.size() == 0) begin
          $display("%0t: report transfer with none expected, expected nothing, got %0d/%0d/%0d",
                   $time, bits_per_ms_i, frames_per_second_i, frames_in_window_i);
          fail_count_o++;
        end else begin
          want = pending_rates.pop_front();
          flag_field("bits_per_ms", want.rate, bits_per_ms_i);
          flag_field("frames_per_second", want.fps, frames_per_second_i);
          flag_field("frames_in_window", want.held, frames_in_window_i);
          checked_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_QUERY) begin
          want = prune_and_rate(now_ms_i);
          if (want.fps == FPS_MAX) clamped_o++;
          if (want.held == '0) empty_o++;
          pending_rates.push_back(want);
        end else begin
          store_frame(now_ms_i, length_bytes_i);
          if (fill > peak_fill_o) peak_fill_o = fill;
        end
      end
      pending_o = pending_rates.size();
    end
  end

endmodule

### sim/sliding_window_rate_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window rate meter testbench
// Directed corner cases, then phases of well-formed frame streams with random
// window settings, sizes, time jumps and late stamps. The sender works in
// bursts and the receiver stalls on its own pattern; the scoreboard checks.
// ----------------------------------------------------------------------------
module sliding_window_rate_meter_tb;
  import swrm_pkg::*;
  import swrm_tb_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  localparam int ITEM_TARGET   = 1750;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 400;
  localparam int CYCLE_LIMIT   = 3_000_000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [WIN_W-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               cmd_i = CMD_RECORD;
  logic [STAMP_W-1:0] now_ms_i = '0;
  logic [LEN_W-1:0]   length_bytes_i = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [TOTAL_W-1:0] bits_per_ms_o;
  logic [FPS_W-1:0]   frames_per_second_o;
  logic [FIW_W-1:0]   frames_in_window_o;

  int fail_count, pending, checked, peak_fill, clamped, empties;

  int unsigned cycle_count = 0;
  int unsigned records_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned burst_left = 0;
  int unsigned windows_written = 0;
  int unsigned win_lo = 32'hFFFF_FFFF;
  int unsigned win_hi = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_run = 0;

  sliding_window_rate_meter dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .cmd_i               (cmd_i),
    .now_ms_i            (now_ms_i),
    .length_bytes_i      (length_bytes_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .bits_per_ms_o       (bits_per_ms_o),
    .frames_per_second_o (frames_per_second_o),
    .frames_in_window_o  (frames_in_window_o)
  );

  rate_meter_scoreboard scoreboard (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_i          (in_stall_o),
    .cmd_i               (cmd_i),
    .now_ms_i            (now_ms_i),
    .length_bytes_i      (length_bytes_i),
    .out_valid_i         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .bits_per_ms_i       (bits_per_ms_o),
    .frames_per_second_i (frames_per_second_o),
    .frames_in_window_i  (frames_in_window_o),
    .fail_count_o        (fail_count),
    .pending_o           (pending),
    .checked_o           (checked),
    .peak_fill_o         (peak_fill),
    .clamped_o           (clamped),
    .empty_o             (empties)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: runs of free flow, random stalls, long holds and short pulses.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_run = $urandom_range(16, 600);
    end
    stall_run--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      3: out_stall_i <= (stall_run % 48) < 40;
      default: out_stall_i <= (stall_run % 7) < 2;
    endcase
  end

  task automatic push_item(input meter_cmd_e c, input logic [STAMP_W-1:0] t,
                           input logic [LEN_W-1:0] n);
    int unsigned gap;
    bit          taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cmd_i <= c;
    now_ms_i <= t;
    length_bytes_i <= n;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end
    if (c == CMD_QUERY) queries_sent++;
    else records_sent++;
  endtask

  task automatic rec(input logic [STAMP_W-1:0] t, input logic [LEN_W-1:0] n);
    push_item(CMD_RECORD, t, n);
  endtask

  // Length is a don't-care on queries, so it carries noise.
  task automatic ask(input logic [STAMP_W-1:0] t);
    push_item(CMD_QUERY, t, LEN_W'($urandom));
  endtask

  // Register writes only once every report is out and the last record is done.
  task automatic set_window(input logic [WIN_W-1:0] w);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    burst_left = 0;
    windows_written++;
    if (w < win_lo) win_lo = w;
    if (w > win_hi) win_hi = w;
  endtask

  function automatic logic [LEN_W-1:0] frame_size();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return LEN_W'($urandom_range(40, 1500));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [WIN_W-1:0]   win;
    logic [STAMP_W-1:0] clock_ms;
    logic [STAMP_W-1:0] t;
    int unsigned        step_max;
    int unsigned        phase_len;
    int unsigned        phase;
    int unsigned        roll;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_window(WINDOW_RESET);

    // Empty ring, zero and full-size frames, span of one, window edge.
    ask(32'd0);
    rec(32'd100, '0);
    rec(32'd100, '1);
    ask(32'd100);
    ask(32'd5100);
    ask(32'd5101);
    // Stamps across the counter wrap, and a newer stamp ahead of now that
    // pruning never reaches.
    rec(32'hFFFF_FFF0, 24'd1);
    rec(32'd5, 24'd2);
    rec(32'd1000, 24'd3);
    ask(32'd20);
    ask(32'd6000);
    // Oldest stamp now lies after the query time: dropped.
    ask(32'd500);
    set_window('0);
    rec(32'd7, 24'd9);
    rec(32'd8, 24'd10);
    ask(32'd8);
    set_window(16'd1);
    rec(32'd50, 24'd5);
    rec(32'd51, 24'd6);
    ask(32'd52);

    phase = 0;
    while (records_sent + queries_sent < ITEM_TARGET) begin
      phase++;
      roll = $urandom_range(0, 5);
      if (phase == 1) win = '1;
      else if (roll == 0) win = 16'd1;
      else if (roll == 1) win = '1;
      else if (roll == 2) win = WIN_W'($urandom_range(1, 64));
      else if (roll == 3) win = WINDOW_RESET;
      else win = WIN_W'($urandom_range(1, 65535));
      set_window(win);
      step_max = (phase == 1) ? 3 : (32'(win) >> $urandom_range(2, 8));
      clock_ms = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 20000)
                                              : STAMP_W'($urandom);
      phase_len = $urandom_range(80, 220);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          clock_ms = STAMP_W'($urandom);
          t = clock_ms;
        end else if (roll < 7) begin
          t = clock_ms - $urandom_range(1, 2 * 32'(win) + 2);
        end else begin
          clock_ms = clock_ms + $urandom_range(0, step_max);
          t = clock_ms;
        end
        if ($urandom_range(0, 99) < 28) ask(t);
        else rec(t, frame_size());
      end
    end

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    $display("Run covered %0d frame records and %0d rate queries, %0d reports checked,",
             records_sent, queries_sent, checked);
    $display("%0d window settings (%0d..%0d ms), peak ring fill %0d, %0d clamped, %0d empty.",
             windows_written, win_lo, win_hi, peak_fill, clamped, empties);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
